[rtl/mbt_pkg.sv]
// Shared constants and command type for the one-bit bitmap transpose store.
package mbt_pkg;

  // Frame geometry
  localparam int unsigned LOGICAL_ROW_BYTES = 52;
  localparam int unsigned NATIVE_ROW_BYTES  = 30;
  localparam int unsigned BLOCK_BYTES       = 8 * LOGICAL_ROW_BYTES;
  localparam int unsigned FRAME_BYTES       = BLOCK_BYTES * NATIVE_ROW_BYTES;

  // Field widths
  localparam int unsigned ADDR_W = 14;
  localparam int unsigned DATA_W = 8;
  localparam int unsigned BIT_W  = 3;

  // Reciprocal for division of a byte address by the native row length
  localparam int unsigned RECIP_SHIFT = 20;
  localparam int unsigned RECIP_MULT  = (2 ** RECIP_SHIFT) / NATIVE_ROW_BYTES + 1;
  localparam int unsigned PROD_W      = ADDR_W + RECIP_SHIFT;
  localparam int unsigned NY_W        = $clog2((2 ** ADDR_W) / NATIVE_ROW_BYTES + 1);
  localparam int unsigned BASE_W      = 32;

  // Request codes
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic wr_en;     // store the incoming logical byte
    logic load;      // capture a read address and its row quotient
    logic base;      // form the first gather address
    logic issue;     // read one logical byte and step to the next row
    logic shift;     // pull the selected bit of the last read byte
    logic out_load;  // move the gathered byte to the output register
  } cmd_t;

endpackage

[rtl/mbt_ctrl.sv]
// Sequencer for the transpose store: handshakes and gather sequencing.
module mbt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          req_type_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output mbt_pkg::cmd_t cmd_o
);
  import mbt_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_BASE   = 3'd1;
  localparam logic [2:0] S_GATHER = 3'd2;
  localparam logic [2:0] S_LAST   = 3'd3;
  localparam logic [2:0] S_HOLD   = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [BIT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             accept;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  // Decode state into commands and next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (req_type_i == REQ_READ) begin
            cmd_o.load = 1'b1;
            state_d    = S_BASE;
          end else begin
            cmd_o.wr_en = 1'b1;
          end
        end
      end
      S_BASE: begin
        cmd_o.base = 1'b1;
        cnt_d      = '0;
        state_d    = S_GATHER;
      end
      S_GATHER: begin
        cmd_o.issue = 1'b1;
        cmd_o.shift = (cnt_q != '0);
        cnt_d       = cnt_q + 1'b1;
        if (cnt_q == '1) begin
          state_d = S_LAST;
        end
      end
      S_LAST: begin
        cmd_o.shift = 1'b1;
        state_d     = S_HOLD;
      end
      S_HOLD: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold the result beat until it is taken
  assign out_valid_d = cmd_o.out_load || (out_valid_q && !out_ready_i);

  // Advance control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[rtl/mbt_datapath.sv]
// Frame memory, address arithmetic and bit gather for the transpose store.
module mbt_datapath (
  input  logic                       clk_i,
  input  mbt_pkg::cmd_t              cmd_i,
  input  logic [mbt_pkg::ADDR_W-1:0] byte_address_i,
  input  logic [mbt_pkg::DATA_W-1:0] write_byte_i,
  output logic [mbt_pkg::DATA_W-1:0] read_byte_o,
  output logic                       range_error_o
);
  import mbt_pkg::*;

  logic [DATA_W-1:0] mem_q [FRAME_BYTES];

  logic [ADDR_W-1:0] k_q;
  logic [NY_W-1:0]   ny_q;
  logic              err_q;
  logic [ADDR_W-1:0] rd_addr_q;
  logic [DATA_W-1:0] rd_data_q;
  logic [DATA_W-1:0] acc_q;
  logic [DATA_W-1:0] read_byte_q;
  logic              range_error_q;

  logic [PROD_W-1:0] prod;
  logic [BASE_W-1:0] base_full;
  logic [BIT_W-1:0]  bit_sel;

  // Row quotient by reciprocal multiply
  assign prod = PROD_W'(byte_address_i) * PROD_W'(RECIP_MULT);

  // First gather address: 416*(k - 30*ny) + ny/8
  assign base_full = BASE_W'(k_q) * BASE_W'(BLOCK_BYTES)
                   - BASE_W'(ny_q) * BASE_W'(FRAME_BYTES)
                   + BASE_W'(ny_q >> BIT_W);

  // Bit of each logical byte that lands in the native byte, MSB for ny mod 8 = 0
  assign bit_sel = BIT_W'(DATA_W - 1) - ny_q[BIT_W-1:0];

  // Store writes, gather reads; one port used per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && (32'(byte_address_i) < FRAME_BYTES)) begin
      mem_q[byte_address_i] <= write_byte_i;
    end
    if (cmd_i.issue && (32'(rd_addr_q) < FRAME_BYTES)) begin
      rd_data_q <= mem_q[rd_addr_q];
    end
  end

  // Address and gather registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      k_q   <= byte_address_i;
      ny_q  <= prod[RECIP_SHIFT +: NY_W];
      err_q <= (32'(byte_address_i) >= FRAME_BYTES);
    end
    if (cmd_i.base) begin
      rd_addr_q <= base_full[ADDR_W-1:0];
    end else if (cmd_i.issue) begin
      rd_addr_q <= rd_addr_q + ADDR_W'(LOGICAL_ROW_BYTES);
    end
    if (cmd_i.shift) begin
      acc_q <= {acc_q[DATA_W-2:0], rd_data_q[bit_sel]};
    end
    if (cmd_i.out_load) begin
      read_byte_q   <= err_q ? '0 : acc_q;
      range_error_q <= err_q;
    end
  end

  assign read_byte_o   = read_byte_q;
  assign range_error_o = range_error_q;

endmodule

[rtl/mono_bitmap_transpose_unit.sv]
// Read: the result beat follows the steps below; a held result stalls the next read.
// Write: the byte is stored at the edge that accepts it; a new beat is taken in the next cycle.
// A read captures the row quotient, forms the base address, makes eight gathers through the
// single-port frame memory, then pulls the last bit and loads the result.
// Reset clears control and the output valid; the frame memory is not cleared.
// Throughput: one write per cycle while no read is in progress; a read blocks the input until its result is loaded.
module mono_bitmap_transpose_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       req_type_i,
  input  logic [mbt_pkg::ADDR_W-1:0] byte_address_i,
  input  logic [mbt_pkg::DATA_W-1:0] write_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [mbt_pkg::DATA_W-1:0] read_byte_o,
  output logic                       range_error_o
);
  import mbt_pkg::*;

  cmd_t cmd;

  // Sequencer
  mbt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // Memory and arithmetic
  mbt_datapath u_datapath (
    .clk_i          (clk_i),
    .cmd_i          (cmd),
    .byte_address_i (byte_address_i),
    .write_byte_i   (write_byte_i),
    .read_byte_o    (read_byte_o),
    .range_error_o  (range_error_o)
  );

`ifndef SYNTHESIS
  // An out-of-range read always carries zero data
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && range_error_o) |-> (read_byte_o == '0))
    else $error("range error beat carries nonzero data");

  // A read beat blocks the input while it is gathered
  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (req_type_i == REQ_READ)) |=> !in_ready_o)
    else $error("input taken during a read gather");

  // After a write beat the input is ready again in the next cycle
  a_write_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (req_type_i == REQ_WRITE)) |=> in_ready_o)
    else $error("input stalled after a write");
`endif

endmodule
